@@ hdl/wrtb_pkg.sv @@
`timescale 1ns / 1ps

package wrtb_pkg;

    localparam int WINDOW_MAX_DEF  = 1024;
    localparam int LENGTH_BITS_DEF = 20;

    localparam int BATCH_W  = 12;
    localparam int CFG_W    = 32;
    localparam int CFG_AW   = 3;
    localparam int WIN_CW   = 11;
    localparam int RATIO_W  = 16;
    localparam int TOKEN_W  = 32;
    localparam int CLASS_W  = 2;

    localparam logic [TOKEN_W-1:0] BUDGET_MAX = 32'h8000_0000;

    localparam logic [CLASS_W-1:0] LC_GEN_HEAVY = 2'd0;
    localparam logic [CLASS_W-1:0] LC_BALANCED  = 2'd1;
    localparam logic [CLASS_W-1:0] LC_CTX_HEAVY = 2'd2;

    localparam logic [CFG_AW-1:0] REG_WINDOW_SIZE  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_RATIO_HEAVY  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_RATIO_BAL    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_TOKENS_HEAVY = 3'd3;
    localparam logic [CFG_AW-1:0] REG_TOKENS_BAL   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_TOKENS_GEN   = 3'd5;

    typedef struct packed {
        logic [WIN_CW-1:0]  window_size;
        logic [RATIO_W-1:0] ratio_heavy_context;
        logic [RATIO_W-1:0] ratio_balanced;
        logic [TOKEN_W-1:0] tokens_heavy_context;
        logic [TOKEN_W-1:0] tokens_balanced;
        logic [TOKEN_W-1:0] tokens_gen_heavy;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT_CHK,
        ST_EVICT_SUB,
        ST_APPEND,
        ST_MUL,
        ST_DIV,
        ST_POW,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic evict_rd;
        logic evict_sub;
        logic append;
        logic mul;
        logic div_step;
        logic pow;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic evict_needed;
        logic sum_zero;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

@@ hdl/wrtb_ctrl.sv @@
`timescale 1ns / 1ps

module wrtb_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              mode,
    output logic              in_ready,
    input  wrtb_pkg::status_t status,
    output wrtb_pkg::cmd_t    cmd
);

    wrtb_pkg::state_t state_reg;
    wrtb_pkg::state_t state_next;
    logic             accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wrtb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wrtb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!mode)
                        state_next = wrtb_pkg::ST_EVICT_CHK;
                    else if (status.sum_zero)
                        state_next = wrtb_pkg::ST_FINISH;
                    else
                        state_next = wrtb_pkg::ST_MUL;
                end
            end
            wrtb_pkg::ST_EVICT_CHK:
            begin
                if (status.evict_needed)
                    state_next = wrtb_pkg::ST_EVICT_SUB;
                else
                    state_next = wrtb_pkg::ST_APPEND;
            end
            wrtb_pkg::ST_EVICT_SUB: state_next = wrtb_pkg::ST_EVICT_CHK;
            wrtb_pkg::ST_APPEND:    state_next = wrtb_pkg::ST_IDLE;
            wrtb_pkg::ST_MUL:       state_next = wrtb_pkg::ST_DIV;
            wrtb_pkg::ST_DIV:
            begin
                if (status.div_last)
                    state_next = wrtb_pkg::ST_POW;
            end
            wrtb_pkg::ST_POW:       state_next = wrtb_pkg::ST_FINISH;
            wrtb_pkg::ST_FINISH:
            begin
                if (status.out_free)
                    state_next = wrtb_pkg::ST_IDLE;
            end
            default:                state_next = wrtb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            wrtb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = accept;
            end
            wrtb_pkg::ST_EVICT_CHK: cmd.evict_rd  = status.evict_needed;
            wrtb_pkg::ST_EVICT_SUB: cmd.evict_sub = 1'b1;
            wrtb_pkg::ST_APPEND:    cmd.append    = 1'b1;
            wrtb_pkg::ST_MUL:       cmd.mul       = 1'b1;
            wrtb_pkg::ST_DIV:       cmd.div_step  = 1'b1;
            wrtb_pkg::ST_POW:       cmd.pow       = 1'b1;
            wrtb_pkg::ST_FINISH:    cmd.finish    = status.out_free;
            default:                cmd           = '0;
        endcase
    end

endmodule

@@ hdl/wrtb_dp.sv @@
`timescale 1ns / 1ps

module wrtb_dp
#(
    parameter int WINDOW_MAX  = wrtb_pkg::WINDOW_MAX_DEF,
    parameter int LENGTH_BITS = wrtb_pkg::LENGTH_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  wrtb_pkg::cfg_t                    cfg,
    input  wrtb_pkg::cmd_t                    cmd,
    output wrtb_pkg::status_t                 status,
    input  logic [LENGTH_BITS-1:0]            in_length,
    input  logic [LENGTH_BITS-1:0]            out_length,
    input  logic [wrtb_pkg::BATCH_W-1:0]      batch_size,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [wrtb_pkg::TOKEN_W-1:0]      token_budget,
    output logic [wrtb_pkg::CLASS_W-1:0]      load_class,
    output logic                              ratio_undefined
);

    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = LENGTH_BITS + $clog2(WINDOW_MAX);
    localparam int DIV_W = SUM_W + wrtb_pkg::BATCH_W;
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam int ADJ_W = (DIV_W + 1 > 33) ? DIV_W + 1 : 33;
    localparam int TW = wrtb_pkg::TOKEN_W;

    logic [LENGTH_BITS-1:0] mem_in  [WINDOW_MAX];
    logic [LENGTH_BITS-1:0] mem_out [WINDOW_MAX];

    logic [LENGTH_BITS-1:0]           len_in_reg, len_out_reg;
    logic [LENGTH_BITS-1:0]           rd_in_reg, rd_out_reg;
    logic [wrtb_pkg::BATCH_W-1:0]     b_reg;
    logic [PTR_W-1:0]                 wp_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic [SUM_W-1:0]                 in_sum_reg, out_sum_reg;
    logic [DIV_W-1:0]                 d1_reg, d2_reg;
    logic [SUM_W-1:0]                 r1_reg, r2_reg;
    logic [DCNT_W-1:0]                dcnt_reg;
    logic [TW-1:0]                    pow_reg;
    logic [wrtb_pkg::CLASS_W-1:0]     cls_reg;
    logic                             out_valid_reg;
    logic [TW-1:0]                    budget_reg;
    logic [wrtb_pkg::CLASS_W-1:0]     class_out_reg;
    logic                             undef_reg;

    logic [31:0]      win_ext, cnt_ext, oldest_ext;
    logic [PTR_W-1:0] oldest;
    logic [SUM_W:0]   sh1, sh2, dvs;
    logic             ge1, ge2;
    logic [ADJ_W-1:0] adj;
    logic [TW-1:0]    smear, pow_next;
    logic [wrtb_pkg::CLASS_W-1:0] cls_next;
    logic [TW-1:0]    thr, budget_next;
    logic [wrtb_pkg::CLASS_W-1:0] class_next;

    // window size clamped to 1..WINDOW_MAX
    always_comb
    begin
        win_ext = {21'd0, cfg.window_size};
        if (win_ext == 32'd0)
            win_ext = 32'd1;
        if (win_ext > 32'(WINDOW_MAX))
            win_ext = 32'(WINDOW_MAX);
        cnt_ext = 32'(count_reg);
        oldest_ext = 32'(wp_reg) + 32'(WINDOW_MAX) - cnt_ext;
        if (oldest_ext >= 32'(WINDOW_MAX))
            oldest_ext = oldest_ext - 32'(WINDOW_MAX);
        oldest = oldest_ext[PTR_W-1:0];
    end

    assign status.evict_needed = (cnt_ext >= win_ext) && (count_reg != '0);
    assign status.sum_zero     = (out_sum_reg == '0);
    assign status.div_last     = (dcnt_reg == DCNT_W'(1));
    assign status.out_free     = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem_in[wp_reg]  <= len_in_reg;
            mem_out[wp_reg] <= len_out_reg;
        end
        if (cmd.evict_rd)
        begin
            rd_in_reg  <= mem_in[oldest];
            rd_out_reg <= mem_out[oldest];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            len_in_reg  <= in_length;
            len_out_reg <= out_length;
            b_reg       <= batch_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            count_reg   <= '0;
            in_sum_reg  <= '0;
            out_sum_reg <= '0;
        end
        else if (cmd.evict_sub)
        begin
            in_sum_reg  <= in_sum_reg - SUM_W'(rd_in_reg);
            out_sum_reg <= out_sum_reg - SUM_W'(rd_out_reg);
            count_reg   <= count_reg - CNT_W'(1);
        end
        else if (cmd.append)
        begin
            in_sum_reg  <= in_sum_reg + SUM_W'(len_in_reg);
            out_sum_reg <= out_sum_reg + SUM_W'(len_out_reg);
            count_reg   <= count_reg + CNT_W'(1);
            if (32'(wp_reg) == 32'(WINDOW_MAX - 1))
                wp_reg <= '0;
            else
                wp_reg <= wp_reg + PTR_W'(1);
        end
    end

    // two restoring dividers sharing the divisor: ratio and scaled batch
    assign dvs = {1'b0, out_sum_reg};
    assign sh1 = {r1_reg, d1_reg[DIV_W-1]};
    assign sh2 = {r2_reg, d2_reg[DIV_W-1]};
    assign ge1 = (sh1 >= dvs);
    assign ge2 = (sh2 >= dvs);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            d1_reg <= DIV_W'({in_sum_reg, 8'd0});
            d2_reg <= DIV_W'(b_reg) * DIV_W'(in_sum_reg);
            r1_reg <= '0;
            r2_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            r1_reg <= ge1 ? SUM_W'(sh1 - dvs) : SUM_W'(sh1);
            r2_reg <= ge2 ? SUM_W'(sh2 - dvs) : SUM_W'(sh2);
            d1_reg <= {d1_reg[DIV_W-2:0], ge1};
            d2_reg <= {d2_reg[DIV_W-2:0], ge2};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.mul)
            dcnt_reg <= DCNT_W'(DIV_W);
        else if (cmd.div_step)
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
    end

    // round adj up to a power of two by smearing adj-1; classify ratio
    always_comb
    begin
        adj   = ADJ_W'(d2_reg) + ADJ_W'(b_reg);
        smear = adj[TW-1:0] - TW'(1);
        for (int i = 0; i < 5; i++)
            smear = smear | (smear >> (1 << i));
        if (adj > ADJ_W'(wrtb_pkg::BUDGET_MAX))
            pow_next = wrtb_pkg::BUDGET_MAX;
        else if (adj == '0)
            pow_next = TW'(1);
        else
            pow_next = smear + TW'(1);

        if (d1_reg > DIV_W'(cfg.ratio_heavy_context))
            cls_next = wrtb_pkg::LC_CTX_HEAVY;
        else if (d1_reg > DIV_W'(cfg.ratio_balanced))
            cls_next = wrtb_pkg::LC_BALANCED;
        else
            cls_next = wrtb_pkg::LC_GEN_HEAVY;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pow)
        begin
            pow_reg <= pow_next;
            cls_reg <= cls_next;
        end
    end

    always_comb
    begin
        case (cls_reg)
            wrtb_pkg::LC_CTX_HEAVY: thr = cfg.tokens_heavy_context;
            wrtb_pkg::LC_BALANCED:  thr = cfg.tokens_balanced;
            default:                thr = cfg.tokens_gen_heavy;
        endcase
        budget_next = (pow_reg > thr) ? pow_reg : thr;
        if (budget_next > wrtb_pkg::BUDGET_MAX)
            budget_next = wrtb_pkg::BUDGET_MAX;
        class_next = cls_reg;
        if (status.sum_zero)
        begin
            budget_next = wrtb_pkg::BUDGET_MAX;
            class_next  = (in_sum_reg != '0) ? wrtb_pkg::LC_CTX_HEAVY
                                             : wrtb_pkg::LC_GEN_HEAVY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            budget_reg    <= budget_next;
            class_out_reg <= class_next;
            undef_reg     <= status.sum_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid       = out_valid_reg;
    assign token_budget    = budget_reg;
    assign load_class      = class_out_reg;
    assign ratio_undefined = undef_reg;

endmodule

@@ hdl/windowed_ratio_token_budget.sv @@
`timescale 1ns / 1ps
// Update transaction: EVICT_CHK, then EVICT_SUB and EVICT_CHK again for each oldest entry
// evicted (usually 1 once full), then APPEND. Query transaction: MUL, DIV through the
// one-bit-per-cycle shared-divisor divider, POW, then FINISH, which registers the result
// once the output is free. Query with zero output sum: goes from accept straight to FINISH.
// One transaction in flight at a time.
// Reset: sums, count, pointer and output valid clear at once; history store is not cleared.

module windowed_ratio_token_budget
#(
    parameter int WINDOW_MAX  = wrtb_pkg::WINDOW_MAX_DEF,
    parameter int LENGTH_BITS = wrtb_pkg::LENGTH_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  logic [LENGTH_BITS-1:0]            in_length,
    input  logic [LENGTH_BITS-1:0]            out_length,
    input  logic [wrtb_pkg::BATCH_W-1:0]      batch_size,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [wrtb_pkg::TOKEN_W-1:0]      token_budget,
    output logic [wrtb_pkg::CLASS_W-1:0]      load_class,
    output logic                              ratio_undefined,
    input  logic                              cfg_we,
    input  logic [wrtb_pkg::CFG_AW-1:0]       cfg_addr,
    input  logic [wrtb_pkg::CFG_W-1:0]        cfg_wdata
);

    wrtb_pkg::cfg_t    cfg_reg;
    wrtb_pkg::cmd_t    cmd;
    wrtb_pkg::status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_size          <= 11'd1024;
            cfg_reg.ratio_heavy_context  <= 16'd2560;
            cfg_reg.ratio_balanced       <= 16'd256;
            cfg_reg.tokens_heavy_context <= 32'd8192;
            cfg_reg.tokens_balanced      <= 32'd4096;
            cfg_reg.tokens_gen_heavy     <= 32'd2048;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                wrtb_pkg::REG_WINDOW_SIZE:
                    cfg_reg.window_size <= cfg_wdata[wrtb_pkg::WIN_CW-1:0];
                wrtb_pkg::REG_RATIO_HEAVY:
                    cfg_reg.ratio_heavy_context <= cfg_wdata[wrtb_pkg::RATIO_W-1:0];
                wrtb_pkg::REG_RATIO_BAL:
                    cfg_reg.ratio_balanced <= cfg_wdata[wrtb_pkg::RATIO_W-1:0];
                wrtb_pkg::REG_TOKENS_HEAVY:
                    cfg_reg.tokens_heavy_context <= cfg_wdata;
                wrtb_pkg::REG_TOKENS_BAL:
                    cfg_reg.tokens_balanced <= cfg_wdata;
                wrtb_pkg::REG_TOKENS_GEN:
                    cfg_reg.tokens_gen_heavy <= cfg_wdata;
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    wrtb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wrtb_dp
    #(
        .WINDOW_MAX  (WINDOW_MAX),
        .LENGTH_BITS (LENGTH_BITS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .status          (status),
        .in_length       (in_length),
        .out_length      (out_length),
        .batch_size      (batch_size),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .token_budget    (token_budget),
        .load_class      (load_class),
        .ratio_undefined (ratio_undefined)
    );

    a_undef_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ratio_undefined |-> token_budget == wrtb_pkg::BUDGET_MAX)
        else $error("undefined ratio without saturated budget");

    a_budget_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_budget != '0 && token_budget <= wrtb_pkg::BUDGET_MAX
                      && load_class != 2'd3)
        else $error("result out of range");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a finished query");

endmodule

@@ tb/windowed_ratio_token_budget_tb.sv @@
`timescale 1ns / 1ps

module windowed_ratio_token_budget_tb;

    localparam bit MODE_RECORD = 1'b0;
    localparam bit MODE_QUERY  = 1'b1;
    localparam int HIST_DEPTH  = wrtb_pkg::WINDOW_MAX_DEF;
    localparam int LEN_W       = wrtb_pkg::LENGTH_BITS_DEF;
    localparam int BATCH_W     = wrtb_pkg::BATCH_W;
    localparam int TOKEN_W     = wrtb_pkg::TOKEN_W;
    localparam int CLASS_W     = wrtb_pkg::CLASS_W;
    localparam int CFG_AW      = wrtb_pkg::CFG_AW;
    localparam int CFG_W       = wrtb_pkg::CFG_W;
    localparam int DRAIN_WAIT  = 2200;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        bit                mode;
        bit [LEN_W-1:0]    in_len;
        bit [LEN_W-1:0]    out_len;
        bit [BATCH_W-1:0]  batch;
    } request_t;

    typedef struct {
        bit [TOKEN_W-1:0]  budget;
        bit [CLASS_W-1:0]  lclass;
        bit                undef;
    } budget_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 mode = 1'b0;
    logic [LEN_W-1:0]     in_length = '0;
    logic [LEN_W-1:0]     out_length = '0;
    logic [BATCH_W-1:0]   batch_size = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [TOKEN_W-1:0]   token_budget;
    logic [CLASS_W-1:0]   load_class;
    logic                 ratio_undefined;
    logic                 cfg_we = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    windowed_ratio_token_budget u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .in_length(in_length), .out_length(out_length),
        .batch_size(batch_size),
        .out_valid(out_valid), .out_ready(out_ready),
        .token_budget(token_budget), .load_class(load_class),
        .ratio_undefined(ratio_undefined),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // window state mirror
    bit [LEN_W-1:0]       hist_in  [HIST_DEPTH];
    bit [LEN_W-1:0]       hist_out [HIST_DEPTH];
    int unsigned          wr_ptr;
    int unsigned          n_entries;
    longint unsigned      sum_in;
    longint unsigned      sum_out;
    wrtb_pkg::cfg_t       regs;

    request_t             pending_q[$];
    budget_t              budget_q[$];
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   mismatches = 0;
    longint               cycles = 0;

    initial forever #4 clk = ~clk;

    function automatic void record_lengths(bit [LEN_W-1:0] il, bit [LEN_W-1:0] ol);
        int unsigned win;
        int unsigned oldest;
        win = regs.window_size;
        if (win == 0) win = 1;
        if (win > HIST_DEPTH) win = HIST_DEPTH;
        while (n_entries >= win && n_entries > 0) begin
            oldest = (wr_ptr + HIST_DEPTH - n_entries) % HIST_DEPTH;
            sum_in  -= hist_in[oldest];
            sum_out -= hist_out[oldest];
            n_entries--;
        end
        hist_in[wr_ptr]  = il;
        hist_out[wr_ptr] = ol;
        sum_in  += il;
        sum_out += ol;
        wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
        n_entries++;
    endfunction

    function automatic budget_t compute_budget(bit [BATCH_W-1:0] b);
        budget_t         r;
        longint unsigned q;
        longint unsigned adj;
        longint unsigned p;
        longint unsigned thr;
        longint unsigned bud;
        if (sum_out == 0) begin
            r.lclass = (sum_in != 0) ? wrtb_pkg::LC_CTX_HEAVY : wrtb_pkg::LC_GEN_HEAVY;
            r.budget = wrtb_pkg::BUDGET_MAX;
            r.undef  = 1'b1;
        end
        else begin
            q = (sum_in << 8) / sum_out;
            if (q > regs.ratio_heavy_context) r.lclass = wrtb_pkg::LC_CTX_HEAVY;
            else if (q > regs.ratio_balanced) r.lclass = wrtb_pkg::LC_BALANCED;
            else r.lclass = wrtb_pkg::LC_GEN_HEAVY;
            adj = b + (longint'(b) * sum_in) / sum_out;
            p = 1;
            while (p < adj && p < wrtb_pkg::BUDGET_MAX) p = p << 1;
            thr = (r.lclass == wrtb_pkg::LC_CTX_HEAVY) ? regs.tokens_heavy_context :
                  (r.lclass == wrtb_pkg::LC_BALANCED)  ? regs.tokens_balanced :
                                                         regs.tokens_gen_heavy;
            bud = (p > thr) ? p : thr;
            if (bud > wrtb_pkg::BUDGET_MAX) bud = wrtb_pkg::BUDGET_MAX;
            r.budget = bud[TOKEN_W-1:0];
            r.undef  = 1'b0;
        end
        return r;
    endfunction

    // driver
    always @(posedge clk) begin
        request_t nxt;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                if (mode == MODE_QUERY)
                    budget_q.insert(budget_q.size(), compute_budget(batch_size));
                else
                    record_lengths(in_length, out_length);
            end
            if (!in_valid || in_ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_q[0];
                    pending_q.delete(0);
                    in_valid   <= 1'b1;
                    mode       <= nxt.mode;
                    in_length  <= nxt.in_len;
                    out_length <= nxt.out_len;
                    batch_size <= nxt.batch;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk) begin
        budget_t exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (budget_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: budget=%0d class=%0d undef=%0d",
                             token_budget, load_class, ratio_undefined);
            end
            else begin
                exp_r = budget_q[0];
                budget_q.delete(0);
                if (token_budget !== exp_r.budget || load_class !== exp_r.lclass ||
                    ratio_undefined !== exp_r.undef) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: budget exp %0d got %0d, ",
                                  "class exp %0d got %0d, undef exp %0d got %0d"},
                                 exp_r.budget, token_budget, exp_r.lclass, load_class,
                                 exp_r.undef, ratio_undefined);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            wrtb_pkg::REG_WINDOW_SIZE:
                regs.window_size = val[wrtb_pkg::WIN_CW-1:0];
            wrtb_pkg::REG_RATIO_HEAVY:
                regs.ratio_heavy_context = val[wrtb_pkg::RATIO_W-1:0];
            wrtb_pkg::REG_RATIO_BAL:
                regs.ratio_balanced = val[wrtb_pkg::RATIO_W-1:0];
            wrtb_pkg::REG_TOKENS_HEAVY: regs.tokens_heavy_context = val;
            wrtb_pkg::REG_TOKENS_BAL:   regs.tokens_balanced      = val;
            wrtb_pkg::REG_TOKENS_GEN:   regs.tokens_gen_heavy     = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int unsigned win, int unsigned rh, int unsigned rb,
                            int unsigned th, int unsigned tb, int unsigned tg);
        write_reg(wrtb_pkg::REG_WINDOW_SIZE, win);
        write_reg(wrtb_pkg::REG_RATIO_HEAVY, rh);
        write_reg(wrtb_pkg::REG_RATIO_BAL, rb);
        write_reg(wrtb_pkg::REG_TOKENS_HEAVY, th);
        write_reg(wrtb_pkg::REG_TOKENS_BAL, tb);
        write_reg(wrtb_pkg::REG_TOKENS_GEN, tg);
    endtask

    // waits out queued stimulus, pending results and any eviction still running
    task automatic drain();
        do @(negedge clk);
        while (pending_q.size() != 0 || in_valid || budget_q.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic request_t rand_request();
        request_t r;
        int       style;
        r.batch   = '0;
        r.in_len  = '0;
        r.out_len = '0;
        if ($urandom_range(99) < 50) begin
            r.mode = MODE_RECORD;
            style  = $urandom_range(4);
            case (style)
                0: begin
                    r.in_len  = LEN_W'($urandom);
                    r.out_len = LEN_W'($urandom);
                end
                1: begin
                    r.in_len  = LEN_W'($urandom_range(255));
                    r.out_len = LEN_W'($urandom_range(255));
                end
                2: begin r.in_len = LEN_W'($urandom_range(4000)); r.out_len = '0; end
                3: begin r.in_len = '0; r.out_len = LEN_W'($urandom_range(4000)); end
                default: begin
                    r.in_len  = LEN_W'($urandom_range(2000));
                    r.out_len = LEN_W'($urandom_range(1, 700));
                end
            endcase
        end
        else begin
            r.mode = MODE_QUERY;
            style  = $urandom_range(9);
            if (style == 0) r.batch = '0;
            else if (style == 1) r.batch = {BATCH_W{1'b1}};
            else if (style < 5) r.batch = BATCH_W'($urandom_range(64));
            else r.batch = BATCH_W'($urandom);
        end
        return r;
    endfunction

    task automatic push_rec(bit [LEN_W-1:0] il, bit [LEN_W-1:0] ol);
        request_t r;
        r.mode = MODE_RECORD; r.in_len = il; r.out_len = ol; r.batch = '0;
        pending_q.insert(pending_q.size(), r);
    endtask

    task automatic push_query(bit [BATCH_W-1:0] b);
        request_t r;
        r.mode = MODE_QUERY; r.in_len = '0; r.out_len = '0; r.batch = b;
        pending_q.insert(pending_q.size(), r);
    endtask

    task automatic run_random(int n, int idle, int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n) pending_q.insert(pending_q.size(), rand_request());
        drain();
    endtask

    initial begin
        regs.window_size          = 1024;
        regs.ratio_heavy_context  = 2560;
        regs.ratio_balanced       = 256;
        regs.tokens_heavy_context = 8192;
        regs.tokens_balanced      = 4096;
        regs.tokens_gen_heavy     = 2048;
        wr_ptr = 0; n_entries = 0; sum_in = 0; sum_out = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty window, infinite ratio, padding and saturation corners
        push_query(0);
        push_query({BATCH_W{1'b1}});
        push_rec(5, 0);
        push_query(7);
        push_rec({LEN_W{1'b1}}, 1);
        push_query(0);
        push_query({BATCH_W{1'b1}});
        push_rec(0, {LEN_W{1'b1}});
        push_query(1);
        push_query({BATCH_W{1'b1}});
        push_rec(0, 0);
        push_query(3);
        push_rec(300, 100);
        push_query(100);
        push_rec(20'h55555, 20'haaaaa);
        push_query(12'h555);
        push_query(12'haaa);
        push_rec(20'haaaaa, 20'h55555);
        push_query(2048);
        drain();

        set_regs(1, 65535, 65535, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_rec(0, 0);
        push_query(9);
        push_rec(1000, 10);
        push_query({BATCH_W{1'b1}});
        run_random(100, 0, 0);

        set_regs(8, 512, 128, 1, 1, 1);
        run_random(110, 48, 0);

        set_regs(1024, 0, 0, 100, 5000, 32'h8000_0000);
        run_random(110, 0, 48);

        // shrink from a long window to a short one
        set_regs(3, 300, 200, 64, 32, 16);
        run_random(110, 21, 21);

        set_regs(40, 1000, 50, 1, 4096, 1024);
        run_random(100, 48, 48);

        if (mismatches == 0 && budget_q.size() == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
